// File: hdl/mpsk_snr_estimator_core_assert.svh
// Assertion macros used by the checker file.
`ifndef MPSK_SNR_ESTIMATOR_CORE_ASSERT_SVH
`define MPSK_SNR_ESTIMATOR_CORE_ASSERT_SVH

// Assert outside of reset.
`define MPSK_SNR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mpsk snr check failed");

// Assert at every edge, reset included.
`define MPSK_SNR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mpsk snr reset check failed");

`endif

// File: hdl/mpsk_snr_pkg.sv
`default_nettype none
package mpsk_snr_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS = 16;
  localparam int ROOT_STEPS = SAMPLE_WIDTH + FRAC_BITS;
  localparam int LOG_STEPS = 16;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [31:0] DB_PER_OCTAVE = 32'd197283;
  localparam logic [24:0] LOG_OFFSET = 25'(FRAC_BITS * 65536);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] i_sample;
    logic signed [SAMPLE_WIDTH-1:0] q_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        mean_estimate;
    logic [47:0]        variance_estimate;
    logic signed [15:0] snr_db;
  } out_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

// File: hdl/mpsk_snr_mul.sv
`default_nettype none
module mpsk_snr_mul (
  input  wire                   clk,
  input  mpsk_snr_pkg::mul_req_t req,
  output logic [63:0]           prod
);
  import mpsk_snr_pkg::*;

  always_ff @(posedge clk) begin
    prod <= 64'(req.a) * 64'(req.b);
  end

endmodule
`default_nettype wire

// File: hdl/mpsk_snr_seq.sv
`default_nettype none
module mpsk_snr_seq (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  mpsk_snr_pkg::in_item_t  item,
  input  wire  [16:0]             gain,
  input  wire                     out_free,
  output logic                    busy,
  output logic                    done,
  output mpsk_snr_pkg::out_item_t res,
  output mpsk_snr_pkg::mul_req_t  mreq,
  input  wire  [63:0]             prod
);
  import mpsk_snr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SQI, S_SQQ, S_SQS, S_ROOT, S_M1, S_M2, S_M3, S_D1, S_D2, S_D3,
    S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_CHK, S_NORM, S_LSQ, S_LUP, S_LCMB,
    S_DB1, S_DB2, S_DONE
  } state_t;

  state_t state;
  logic [15:0] ia, qa;
  logic [16:0] alpha, beta;
  logic [65:0] acc;
  logic [31:0] s;
  logic [33:0] rem;
  logic [31:0] root;
  logic [4:0]  cnt;
  logic [31:0] mean, dev;
  logic [47:0] dev2, var_q;
  logic [47:0] x;
  logic [5:0]  p;
  logic [2:0]  nstep;
  logic [31:0] m;
  logic [15:0] frac;
  logic        lsel;
  logic [21:0] lmean, lvar;
  logic        lneg;
  logic [23:0] labs;
  logic signed [15:0] snr;

  logic [35:0] rem_sh, trial;
  logic [47:0] x_next;
  logic [5:0]  p_next;
  logic [31:0] t;
  logic [15:0] frac_next;
  logic [24:0] l;
  logic [42:0] rnd;
  logic [17:0] dbmag;
  logic [65:0] sum;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE) && out_free;
  assign res.mean_estimate = mean;
  assign res.variance_estimate = var_q;
  assign res.snr_db = snr;

  always_comb begin
    mreq = '0;
    unique case (state)
      S_SQI:   mreq = '{a: 32'(ia), b: 32'(ia)};
      S_SQQ:   mreq = '{a: 32'(qa), b: 32'(qa)};
      S_M1:    mreq = '{a: 32'(alpha), b: root};
      S_M2:    mreq = '{a: 32'(beta), b: mean};
      S_D2:    mreq = '{a: dev, b: dev};
      S_V1:    mreq = '{a: 32'(alpha), b: 32'(dev2[23:0])};
      S_V2:    mreq = '{a: 32'(alpha), b: 32'(dev2[47:24])};
      S_V3:    mreq = '{a: 32'(beta), b: 32'(var_q[23:0])};
      S_V4:    mreq = '{a: 32'(beta), b: 32'(var_q[47:24])};
      S_LSQ:   mreq = '{a: m, b: m};
      S_DB1:   mreq = '{a: 32'(labs), b: DB_PER_OCTAVE};
      default: mreq = '0;
    endcase
  end

  always_comb begin
    rem_sh = {rem, s[31:30]};
    trial = {2'b00, root, 2'b01};
    sum = acc + 66'(prod);
    t = prod[61:30];
    frac_next = {frac[14:0], t[31]};
    l = {2'b00, lmean, 1'b0} - {3'b000, lvar} - LOG_OFFSET;
    rnd = prod[42:0] + 43'd8388608;
    dbmag = rnd[41:24];
    x_next = x;
    p_next = p;
    case (nstep)
      3'd0: if (x[47:16] == '0) begin x_next = {x[15:0], 32'b0}; p_next = p - 6'd32; end
      3'd1: if (x[47:32] == '0) begin x_next = {x[31:0], 16'b0}; p_next = p - 6'd16; end
      3'd2: if (x[47:40] == '0) begin x_next = {x[39:0], 8'b0}; p_next = p - 6'd8; end
      3'd3: if (x[47:44] == '0) begin x_next = {x[43:0], 4'b0}; p_next = p - 6'd4; end
      3'd4: if (x[47:46] == '0) begin x_next = {x[45:0], 2'b0}; p_next = p - 6'd2; end
      3'd5: if (!x[47]) begin x_next = {x[46:0], 1'b0}; p_next = p - 6'd1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mean <= '0;
      var_q <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ia <= item.i_sample[15] ? 16'(-item.i_sample) : 16'(item.i_sample);
            qa <= item.q_sample[15] ? 16'(-item.q_sample) : 16'(item.q_sample);
            alpha <= (gain > ALPHA_ONE) ? ALPHA_ONE : gain;
            beta <= ALPHA_ONE - ((gain > ALPHA_ONE) ? ALPHA_ONE : gain);
            state <= S_SQI;
          end
        end
        S_SQI: state <= S_SQQ;
        S_SQQ: begin
          acc <= 66'(prod);
          state <= S_SQS;
        end
        S_SQS: begin
          s <= acc[31:0] + prod[31:0];
          rem <= '0;
          root <= '0;
          cnt <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (rem_sh >= trial) begin
            rem <= 34'(rem_sh - trial);
            root <= {root[30:0], 1'b1};
          end else begin
            rem <= rem_sh[33:0];
            root <= {root[30:0], 1'b0};
          end
          s <= {s[29:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ROOT_STEPS - 1)) state <= S_M1;
        end
        S_M1: state <= S_M2;
        S_M2: begin
          acc <= 66'(prod);
          state <= S_M3;
        end
        S_M3: begin
          mean <= sum[47:16];
          state <= S_D1;
        end
        S_D1: begin
          dev <= (root >= mean) ? root - mean : mean - root;
          state <= S_D2;
        end
        S_D2: state <= S_D3;
        S_D3: begin
          dev2 <= prod[63:16];
          state <= S_V1;
        end
        S_V1: state <= S_V2;
        S_V2: begin
          acc <= 66'(prod);
          state <= S_V3;
        end
        S_V3: begin
          acc <= acc + {prod[41:0], 24'b0};
          state <= S_V4;
        end
        S_V4: begin
          acc <= sum;
          state <= S_V5;
        end
        S_V5: begin
          acc <= acc + {prod[41:0], 24'b0};
          state <= S_V6;
        end
        S_V6: begin
          var_q <= acc[63:16];
          state <= S_CHK;
        end
        S_CHK: begin
          x <= {16'b0, mean};
          p <= 6'd47;
          nstep <= '0;
          lsel <= 1'b0;
          if (var_q == '0) begin
            snr <= '0;
            state <= S_DONE;
          end else if (mean == '0) begin
            snr <= 16'sh8000;
            state <= S_DONE;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          x <= x_next;
          p <= p_next;
          nstep <= nstep + 3'd1;
          if (nstep == 3'd5) begin
            m <= {1'b0, x_next[47:17]};
            frac <= '0;
            cnt <= '0;
            state <= S_LSQ;
          end
        end
        S_LSQ: state <= S_LUP;
        S_LUP: begin
          frac <= frac_next;
          m <= t[31] ? {1'b0, t[31:1]} : t;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(LOG_STEPS - 1)) begin
            if (!lsel) begin
              lmean <= {p, frac_next};
              x <= var_q;
              p <= 6'd47;
              nstep <= '0;
              lsel <= 1'b1;
              state <= S_NORM;
            end else begin
              lvar <= {p, frac_next};
              state <= S_LCMB;
            end
          end else begin
            state <= S_LSQ;
          end
        end
        S_LCMB: begin
          lneg <= l[24];
          labs <= l[24] ? 24'(-l) : l[23:0];
          state <= S_DB1;
        end
        S_DB1: state <= S_DB2;
        S_DB2: begin
          if (!lneg) begin
            snr <= (dbmag > 18'd32767) ? 16'sh7fff : 16'(dbmag);
          end else begin
            snr <= (dbmag > 18'd32768) ? 16'sh8000 : 16'(-dbmag);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/mpsk_snr_estimator_core.sv
// M-PSK SNR estimator core.
// Input channel: sample_valid / sample_stall carry one complex sample (I, Q).
// Output channel: result_valid / result_stall carry the updated mean,
// variance and SNR in dB (Q8.8) for every sample taken.
// Configuration: gain_we writes gain_data (alpha, Q1.16) at that edge; write
// it only while the block is idle.
// Flow: one item at a time. The 32-step square root runs bit by bit, and the
// two log2 runs of 16 squarings each use the shared 32x32 multiplier; the
// log2 runs are skipped when the variance or the mean is zero. sample_stall
// is high while an item is being worked on.
// Reset clears the mean, the variance and the output valid, and loads the
// gain with 7.
// A stalled result holds; the next item may be taken meanwhile, and its
// finished result waits inside until the output register is free.
`default_nettype none
module mpsk_snr_estimator_core (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     sample_valid,
  output logic                    sample_stall,
  input  mpsk_snr_pkg::in_item_t  sample,
  output logic                    result_valid,
  input  wire                     result_stall,
  output mpsk_snr_pkg::out_item_t result,
  input  wire                     gain_we,
  input  wire  [16:0]             gain_data
);
  import mpsk_snr_pkg::*;

  logic [16:0] gain;
  logic        busy, done, out_free;
  out_item_t   res;
  mul_req_t    mreq;
  logic [63:0] prod;

  assign sample_stall = busy;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 17'd7;
      result_valid <= 1'b0;
    end else begin
      if (gain_we) gain <= gain_data;
      if (done) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) result <= res;
  end

  mpsk_snr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (sample_valid && !busy),
    .item     (sample),
    .gain     (gain),
    .out_free (out_free),
    .busy     (busy),
    .done     (done),
    .res      (res),
    .mreq     (mreq),
    .prod     (prod)
  );

  mpsk_snr_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

endmodule
`default_nettype wire

// File: hdl/mpsk_snr_chk.sv
`default_nettype none
`include "mpsk_snr_estimator_core_assert.svh"
module mpsk_snr_chk (
  input wire                     clk,
  input wire                     rst,
  input wire                     sample_valid,
  input wire                     sample_stall,
  input wire                     result_valid,
  input wire                     result_stall,
  input mpsk_snr_pkg::out_item_t result
);
  import mpsk_snr_pkg::*;

  `MPSK_SNR_ASSERT(a_hold, result_valid && result_stall |=> result_valid)
  `MPSK_SNR_ASSERT(a_busy, sample_valid && !sample_stall |=> sample_stall)
  `MPSK_SNR_ASSERT(a_zero_var, result_valid && (result.variance_estimate == '0) |-> (result.snr_db == '0))
  `MPSK_SNR_ASSERT(a_zero_mean, result_valid && (result.mean_estimate == '0) && (result.variance_estimate != '0) |-> (result.snr_db == 16'sh8000))
  `MPSK_SNR_ASSERT_ALWAYS(a_reset, $past(rst) |-> !result_valid)

endmodule

bind mpsk_snr_estimator_core mpsk_snr_chk u_chk (.*);
`default_nettype wire

// File: tb/mpsk_snr_estimator_core_test.sv
`default_nettype none
module mpsk_snr_estimator_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mpsk_snr_pkg::*;

  logic        clk;
  logic        rst;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  in_item_t    sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        gain_we;
  logic [16:0] gain_data;

  mpsk_snr_estimator_core u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .gain_we(gain_we), .gain_data(gain_data)
  );

  in_item_t  pending_samples[$];
  out_item_t expected_results[$];
  logic [16:0] model_gain;
  logic [31:0] model_mean = '0;
  logic [47:0] model_var = '0;
  int  errors = 0;
  int  cycles = 0;
  int  send_gap;
  int  recv_gap;
  bit  driver_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] isqrt_mag(logic [63:0] s);
    logic [65:0] rem;
    logic [65:0] root;
    logic [65:0] trial;
    logic [1:0]  bits;
    int pos;
    rem = '0;
    root = '0;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      pos = 2 * (ROOT_STEPS - 1 - k);
      bits = (pos >= 2 * FRAC_BITS) ? 2'(s >> (pos - 2 * FRAC_BITS)) : 2'b00;
      rem = (rem << 2) | 66'(bits);
      trial = (root << 2) | 66'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 66'd1;
      end else begin
        root = root << 1;
      end
    end
    return (root > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
  endfunction

  function automatic longint log2_fixed(logic [63:0] x);
    int p;
    logic [63:0]  m;
    logic [127:0] sq;
    longint frac;
    p = 63;
    frac = 0;
    while (p > 0 && !x[p]) p--;
    if (p >= 30) m = x >> (p - 30);
    else m = x << (30 - p);
    for (int k = 0; k < LOG_STEPS; k++) begin
      sq = 128'(m) * 128'(m);
      m = 64'(sq >> 30);
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(p) * 65536 + frac;
  endfunction

  function automatic logic signed [15:0] snr_from(logic [31:0] mean, logic [47:0] var_v);
    longint l;
    longint prod;
    longint q8;
    if (var_v == 0) return 16'sd0;
    if (mean == 0) return -16'sd32768;
    l = 2 * log2_fixed(64'(mean)) - log2_fixed(64'(var_v)) - longint'(FRAC_BITS) * 65536;
    prod = l * 197283;
    if (prod >= 0) q8 = (prod + (64'sd1 <<< 23)) / (64'sd1 <<< 24);
    else q8 = -((-prod + (64'sd1 <<< 23)) / (64'sd1 <<< 24));
    if (q8 > 32767) return 16'sd32767;
    if (q8 < -32768) return -16'sd32768;
    return 16'(q8);
  endfunction

  function automatic out_item_t update_estimate(in_item_t s);
    logic [16:0] ia;
    logic [16:0] qa;
    logic [63:0] alpha;
    logic [63:0] beta;
    logic [31:0] mag;
    logic [63:0] acc;
    logic [31:0] dev;
    logic [63:0] dev2;
    logic [127:0] vacc;
    out_item_t r;
    ia = s.i_sample[15] ? 17'(-$signed({s.i_sample[15], s.i_sample})) : 17'(s.i_sample);
    qa = s.q_sample[15] ? 17'(-$signed({s.q_sample[15], s.q_sample})) : 17'(s.q_sample);
    alpha = (model_gain > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(model_gain);
    beta = 64'(ALPHA_ONE) - alpha;
    mag = isqrt_mag(64'(ia) * 64'(ia) + 64'(qa) * 64'(qa));
    acc = (alpha * 64'(mag) + beta * 64'(model_mean)) >> 16;
    model_mean = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    dev = (mag >= model_mean) ? mag - model_mean : model_mean - mag;
    dev2 = (64'(dev) * 64'(dev)) >> FRAC_BITS;
    if (dev2 > 64'hFFFF_FFFF_FFFF) dev2 = 64'hFFFF_FFFF_FFFF;
    vacc = (128'(alpha) * 128'(dev2) + 128'(beta) * 128'(model_var)) >> 16;
    model_var = (vacc > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : vacc[47:0];
    r.mean_estimate = model_mean;
    r.variance_estimate = model_var;
    r.snr_db = snr_from(model_mean, model_var);
    return r;
  endfunction

  task automatic queue_sample(logic [15:0] i_v, logic [15:0] q_v);
    in_item_t s;
    s.i_sample = i_v;
    s.q_sample = q_v;
    pending_samples.push_back(s);
  endtask

  task automatic write_gain(logic [16:0] g);
    @(posedge clk);
    gain_we <= 1'b1;
    gain_data <= g;
    @(posedge clk);
    gain_we <= 1'b0;
    model_gain = g;
  endtask

  task automatic drain;
    while (pending_samples.size() != 0 || !driver_idle || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    int amp;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: queue_sample(16'($urandom), 16'($urandom));
        1: queue_sample($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                        $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
        2: queue_sample(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
        default: begin
          amp = $urandom_range(0, 1) ? 20000 : 300;
          queue_sample(($urandom_range(0, 1) ? 16'(amp) : 16'(-amp))
                         + 16'($urandom_range(0, 63)),
                       ($urandom_range(0, 1) ? 16'(amp) : 16'(-amp))
                         + 16'($urandom_range(0, 63)));
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap <= 0;
      driver_idle <= 1'b1;
    end else if (sample_valid && !sample_stall) begin
      expected_results.push_back(update_estimate(sample));
      sample_valid <= 1'b0;
      send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      driver_idle <= 1'b1;
    end else if (!sample_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() != 0) begin
        sample <= pending_samples.pop_front();
        sample_valid <= 1'b1;
        driver_idle <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      result_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result.mean_estimate !== exp_r.mean_estimate) begin
            $error("mean_estimate exp %0d got %0d", exp_r.mean_estimate, result.mean_estimate);
            errors++;
          end
          if (result.variance_estimate !== exp_r.variance_estimate) begin
            $error("variance_estimate exp %0d got %0d",
                   exp_r.variance_estimate, result.variance_estimate);
            errors++;
          end
          if (result.snr_db !== exp_r.snr_db) begin
            $error("snr_db exp %0d got %0d", exp_r.snr_db, result.snr_db);
            errors++;
          end
        end
        recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        result_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    model_gain = 17'd7;
    rst = 1'b1;
    gain_we = 1'b0;
    gain_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h7FFF, 16'h7FFF);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'h8000, 16'h7FFF);
    queue_sample(16'h0001, 16'hFFFF);
    drain();

    write_gain(17'd65536);
    queue_sample(16'h4000, 16'h0000);
    queue_sample(16'h4000, 16'h0000);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h0001, 16'h0000);
    queue_sample(16'h8000, 16'h8000);
    drain();

    write_gain(17'h1FFFF);
    queue_sample(16'h1234, 16'hC000);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h7FFF, 16'h0000);
    drain();

    write_gain(17'd0);
    queue_sample(16'h7FFF, 16'h8000);
    queue_sample(16'h0010, 16'h0010);
    drain();

    write_gain(17'd32768);
    queue_sample(16'h0100, 16'h0100);
    queue_sample(16'hFF00, 16'h0100);
    queue_sample(16'h0000, 16'h0000);
    drain();

    write_gain(17'd4096);
    queue_random(150);
    drain();
    write_gain(17'd65535);
    queue_random(100);
    drain();
    write_gain(17'($urandom));
    queue_random(100);
    drain();
    write_gain(17'd1);
    queue_random(100);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
